>>> rtl/core/otb_pkg.sv
`timescale 1ns / 1ps

package otb_pkg;

  localparam int NUM_TIMERS_DEF = 4;
  localparam int ID_SPACE       = 8;

  localparam int FUNC_W  = 3;
  localparam int ID_W    = 3;
  localparam int JIFFY_W = 16;
  localparam int MASK_W  = 8;

  localparam logic [FUNC_W-1:0] OP_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] OP_ONESHOT  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_PERIODIC = 3'd2;
  localparam logic [FUNC_W-1:0] OP_CANCEL   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_QUERY    = 3'd4;

  // Decoded command from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic id_ok;
    logic tick;
    logic oneshot;
    logic periodic;
    logic cancel;
    logic query;
  } otb_cmd_t;

endpackage

>>> rtl/core/otb_in_if.sv
`timescale 1ns / 1ps

interface otb_in_if;
  import otb_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ID_W-1:0]    slot;
  logic [JIFFY_W-1:0] delay;
  logic [JIFFY_W-1:0] now;

  modport source (output valid, func, slot, delay, now, input ready);
  modport sink   (input valid, func, slot, delay, now, output ready);
endinterface

>>> rtl/core/otb_out_if.sv
`timescale 1ns / 1ps

interface otb_out_if;
  import otb_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fired_mask;
  logic              running;

  modport source (output valid, fired_mask, running, input ready);
  modport sink   (input valid, fired_mask, running, output ready);
endinterface

>>> rtl/core/otb_ctrl.sv
`timescale 1ns / 1ps

module otb_ctrl
  import otb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] func,
  input  logic [ID_W-1:0]   slot,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output otb_cmd_t          cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // Take a new item when the result register is empty or being drained.
  assign in_ready  = (state == ST_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_FULL);

  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (accept)         state_next = ST_FULL;
        else if (out_ready) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_EMPTY;
    else     state <= state_next;
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.id_ok    = ({1'b0, slot} < (ID_W + 1)'(NUM_TIMERS));
    case (func)
      OP_TICK:     cmd.tick     = 1'b1;
      OP_ONESHOT:  cmd.oneshot  = 1'b1;
      OP_PERIODIC: cmd.periodic = 1'b1;
      OP_CANCEL:   cmd.cancel   = 1'b1;
      OP_QUERY:    cmd.query    = 1'b1;
      default:     ;
    endcase
  end

endmodule

>>> rtl/core/otb_dp.sv
`timescale 1ns / 1ps

module otb_dp
  import otb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  otb_cmd_t           cmd,
  input  logic [ID_W-1:0]    slot,
  input  logic [JIFFY_W-1:0] delay,
  input  logic [JIFFY_W-1:0] now,
  output logic [MASK_W-1:0]  fired_mask,
  output logic               running
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [JIFFY_W-1:0]    deadline        [NUM_TIMERS];
  logic [JIFFY_W-1:0]    reload_interval [NUM_TIMERS];
  logic [JIFFY_W-1:0]    reload_val      [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fire;
  logic [NUM_TIMERS-1:0] sel;
  logic [MASK_W-1:0]     fire_mask;
  logic [JIFFY_W-1:0]    arm_sum;
  logic                  sel_running;
  logic [IDX_W-1:0]      idx;

  assign idx     = slot[IDX_W-1:0];
  assign arm_sum = now + delay;

  always_comb begin
    fire_mask   = '0;
    sel_running = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      fire[i]       = (deadline[i] != '0) && (now >= deadline[i]);
      reload_val[i] = (reload_interval[i] != '0) ? JIFFY_W'(now + reload_interval[i]) : '0;
      sel[i]        = cmd.id_ok && (idx == IDX_W'(i));
      fire_mask[i]  = fire[i];
      if (sel[i] && (deadline[i] != '0)) sel_running = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (rst) begin
        deadline[i]        <= '0;
        reload_interval[i] <= '0;
      end else if (cmd.load) begin
        if (cmd.tick && fire[i]) begin
          deadline[i] <= reload_val[i];
        end else if (sel[i] && (cmd.oneshot || cmd.periodic)) begin
          deadline[i]        <= arm_sum;
          reload_interval[i] <= cmd.periodic ? delay : '0;
        end else if (sel[i] && cmd.cancel) begin
          deadline[i] <= '0;
        end
      end
    end
  end

  // Result register; holds while the output side stalls.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fired_mask <= cmd.tick ? fire_mask : '0;
      running    <= cmd.query && sel_running;
    end
  end

endmodule

>>> rtl/core/oneshot_periodic_timer_bank_unit.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS 16-bit deadline timers. Each input item is one
// operation (tick, arm one-shot, arm periodic, cancel, query) and yields
// exactly one result item in the cycle after it is accepted. The bank takes
// one item per clock: all timers are compared and reloaded in parallel,
// and the result register frees up in the same cycle it is read, so the
// input stalls only while an unread result is held.
module oneshot_periodic_timer_bank_unit
  import otb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input logic       clk,
  input logic       rst,
  otb_in_if.sink    in_ch,
  otb_out_if.source out_ch
);

  otb_cmd_t cmd;

  otb_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .func      (in_ch.func),
    .slot      (in_ch.slot),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  otb_dp #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .slot       (in_ch.slot),
    .delay      (in_ch.delay),
    .now        (in_ch.now),
    .fired_mask (out_ch.fired_mask),
    .running    (out_ch.running)
  );

endmodule
